// File: hdl/fpbf_pkg.sv
package fpbf_pkg;

    localparam int RATE_W     = 22;
    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 17;
    localparam int PEAK_W     = 9;
    localparam int FREQ_W     = 21;
    localparam int V_W        = 34;
    localparam int CSU_W      = 36;
    localparam int MUL_B_W    = 16;
    localparam int MUL_P_W    = RATE_W + MUL_B_W;
    localparam int SQRT_STEPS = 17;

    localparam logic [RATE_W-1:0] RATE_RESET = 22'd1000000;
    localparam logic [MAG_W-1:0]  MAG_MAX    = 17'd92681;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] bin_real;
        logic signed [SAMPLE_W-1:0] bin_imag;
    } t_in_item;

    typedef struct packed {
        logic [MAG_W-1:0]  magnitude;
        logic [PEAK_W-1:0] peak_bin;
        logic [FREQ_W-1:0] frequency_hz;
        logic              frame_done;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_RE,
        S_SQ_IM,
        S_SUM,
        S_SQRT,
        S_UPD,
        S_MUL,
        S_LOAD,
        S_DONE
    } t_state;

endpackage

// File: hdl/fpbf_csu.sv
module fpbf_csu
    import fpbf_pkg::*;
(
    input  logic [CSU_W-1:0] i_a,
    input  logic [CSU_W-1:0] i_b,
    output logic [CSU_W-1:0] o_diff,
    output logic             o_ge
);

    logic borrow;

    assign {borrow, o_diff} = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge = !borrow;

endmodule

// File: hdl/fpbf_mul.sv
module fpbf_mul
    import fpbf_pkg::*;
(
    input  logic                i_clk,
    input  logic [RATE_W-1:0]   i_a,
    input  logic [MUL_B_W-1:0]  i_b,
    output logic [MUL_P_W-1:0]  o_prod
);

    logic [MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// File: hdl/fft_peak_bin_frequency.sv
// Each bin passes from acceptance to a valid result in order: S_SQ_RE, S_SQ_IM and S_SUM square
// and sum its parts, 17 square root steps follow, then S_UPD and S_DONE update the peak and write back.
// For the last bin of a frame, S_MUL and S_LOAD form the rate times peak product and shift it down.
// A new bin is accepted only in S_IDLE, after the previous result is written, so bins are not
// overlapped; a stalled output holds the sequencer in S_DONE.
// Synchronous active-low reset restores the sample rate to 1000000 and restarts the frame.
module fft_peak_bin_frequency
    import fpbf_pkg::*;
#(
    parameter int FFT_POINTS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [RATE_W-1:0] i_cfg_data
);

    localparam int HALF = FFT_POINTS / 2;
    localparam int IW   = $clog2(HALF);
    localparam int PW   = RATE_W + IW;
    localparam int DW   = $clog2(FFT_POINTS);
    localparam int KW   = $clog2(SQRT_STEPS);
    localparam logic [IW-1:0] LAST_IDX  = IW'(HALF - 1);
    localparam logic [KW-1:0] SQRT_TOP  = KW'(SQRT_STEPS - 1);

    t_state r_state, n_state;

    logic [RATE_W-1:0]   r_rate;
    logic [IW-1:0]       r_cnt;
    logic [MAG_W-1:0]    r_best_mag;
    logic [IW-1:0]       r_best_idx;
    logic                r_out_valid;
    t_out_item           r_out_data;

    logic [SAMPLE_W-1:0] r_re, r_im;
    logic [31:0]         r_acc;
    logic [V_W-1:0]      r_v;
    logic [V_W:0]        r_root;
    logic [KW-1:0]       r_k;
    logic [MAG_W-1:0]    r_mag;
    logic [FREQ_W-1:0]   r_freq;
    logic                r_last;

    logic [RATE_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [MUL_P_W-1:0]  mul_p;
    logic [CSU_W-1:0]    csu_a, csu_b, csu_diff;
    logic                csu_ge;
    logic [V_W-1:0]      sq_bit;
    logic [MAG_W-1:0]    mag_now;
    logic                in_take, done_go;

    fpbf_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_p)
    );

    fpbf_csu u_csu (
        .i_a    (csu_a),
        .i_b    (csu_b),
        .o_diff (csu_diff),
        .o_ge   (csu_ge)
    );

    assign in_take = i_in_valid && (r_state == S_IDLE);
    assign done_go = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign sq_bit  = V_W'(1) << {r_k, 1'b0};
    assign mag_now = r_root[MAG_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_SQ_RE;
            S_SQ_RE: n_state = S_SQ_IM;
            S_SQ_IM: n_state = S_SUM;
            S_SUM:   n_state = S_SQRT;
            S_SQRT:  if (r_k == '0) n_state = S_UPD;
            S_UPD:   n_state = (r_cnt == LAST_IDX) ? S_MUL : S_DONE;
            S_MUL:   n_state = S_LOAD;
            S_LOAD:  n_state = S_DONE;
            S_DONE:  if (done_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        csu_a = '0;
        csu_b = '0;
        case (r_state)
            S_SQ_RE: begin
                mul_a = RATE_W'(r_re);
                mul_b = r_re;
            end
            S_SQ_IM: begin
                mul_a = RATE_W'(r_im);
                mul_b = r_im;
            end
            S_MUL: begin
                mul_a = r_rate;
                mul_b = MUL_B_W'(r_best_idx);
            end
            S_SQRT: begin
                csu_a = CSU_W'(r_v);
                csu_b = CSU_W'(r_root | {1'b0, sq_bit});
            end
            S_UPD: begin
                csu_a = CSU_W'(mag_now);
                csu_b = CSU_W'(r_best_mag);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate      <= RATE_RESET;
            r_cnt       <= '0;
            r_best_mag  <= '0;
            r_best_idx  <= IW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_rate <= i_cfg_data;
            end
            if (r_state == S_UPD && r_cnt != '0 && csu_ge) begin
                r_best_mag <= mag_now;
                r_best_idx <= r_cnt;
            end
            if (done_go) begin
                r_out_valid <= 1'b1;
                if (r_last) begin
                    r_cnt      <= '0;
                    r_best_mag <= '0;
                    r_best_idx <= IW'(1);
                end else begin
                    r_cnt <= r_cnt + IW'(1);
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_re <= i_in_data.bin_real[SAMPLE_W-1] ? SAMPLE_W'(~i_in_data.bin_real + 1'b1)
                                                   : i_in_data.bin_real;
            r_im <= i_in_data.bin_imag[SAMPLE_W-1] ? SAMPLE_W'(~i_in_data.bin_imag + 1'b1)
                                                   : i_in_data.bin_imag;
        end
        case (r_state)
            S_SQ_IM: begin
                r_acc <= mul_p[31:0];
            end
            S_SUM: begin
                r_v    <= {V_W'(r_acc) + V_W'(mul_p[31:0])} << 2;
                r_root <= '0;
                r_k    <= SQRT_TOP;
            end
            S_SQRT: begin
                if (csu_ge) begin
                    r_v    <= csu_diff[V_W-1:0];
                    r_root <= (r_root >> 1) | {1'b0, sq_bit};
                end else begin
                    r_root <= r_root >> 1;
                end
                r_k <= r_k - KW'(1);
            end
            S_UPD: begin
                r_mag  <= (r_cnt == '0) ? (mag_now >> 1) : mag_now;
                r_last <= (r_cnt == LAST_IDX);
            end
            S_LOAD: begin
                r_freq <= FREQ_W'(mul_p[PW-1:DW]);
            end
            default: begin
                r_k <= r_k;
            end
        endcase
        if (done_go) begin
            r_out_data.magnitude    <= r_mag;
            r_out_data.peak_bin     <= PEAK_W'(r_best_idx);
            r_out_data.frequency_hz <= r_last ? r_freq : '0;
            r_out_data.frame_done   <= r_last;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = (r_state == S_IDLE);

    a_take_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted without the sequencer leaving idle");

    a_best_idx_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_idx != '0)
        else $error("peak index fell to bin zero");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result written outside the final state");

    a_mag_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.magnitude <= MAG_MAX))
        else $error("magnitude beyond its range");

endmodule
